// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent holds.
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// File: hw/rtl/sts_pkg.sv
package sts_pkg;

    localparam int OffsetBits = 24;
    localparam int ValueBits  = 31;
    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    localparam logic [ValueBits-1:0] ValueMax = {ValueBits{1'b1}};
    localparam logic [OffsetBits:0]  OffLimit = {1'b1, {OffsetBits{1'b0}}};

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_ZERO, M_BADNUM, M_NUM, M_IDENT,
        M_LT, M_GT, M_EQ, M_BANG, M_AMP, M_BAR
    } t_mode;

    // Operator token kinds, in the order the scanner numbers them.
    localparam logic [5:0] K_LBRACE = 6'd0,  K_RBRACE = 6'd1,  K_LBRACK = 6'd2;
    localparam logic [5:0] K_RBRACK = 6'd3,  K_LPAREN = 6'd4,  K_RPAREN = 6'd5;
    localparam logic [5:0] K_SEMI   = 6'd6,  K_COLON  = 6'd7,  K_COMMA  = 6'd8;
    localparam logic [5:0] K_ASSIGN = 6'd9,  K_EQ     = 6'd10, K_PLUS   = 6'd11;
    localparam logic [5:0] K_MINUS  = 6'd12, K_STAR   = 6'd13, K_MOD    = 6'd15;
    localparam logic [5:0] K_LT     = 6'd16, K_LE     = 6'd17, K_SHL    = 6'd18;
    localparam logic [5:0] K_NOT    = 6'd19, K_NE     = 6'd20, K_GT     = 6'd21;
    localparam logic [5:0] K_GE     = 6'd22, K_SHR    = 6'd23, K_AMP    = 6'd24;
    localparam logic [5:0] K_ANDAND = 6'd25, K_BAR    = 6'd26, K_OROR   = 6'd27;

    localparam logic [5:0] K_DIV      = 6'd14;
    localparam logic [5:0] K_NUMBER   = 6'd28;
    localparam logic [5:0] K_IDENT    = 6'd29;
    localparam logic [5:0] K_KW_BASE  = 6'd30;
    localparam logic [5:0] K_LINECOM  = 6'd37;
    localparam logic [5:0] K_BLOCKCOM = 6'd38;
    localparam logic [5:0] K_ERROR    = 6'd39;
    localparam logic [5:0] K_END      = 6'd40;
    // Marks an empty token slot inside the front end.
    localparam logic [5:0] K_NONE     = 6'd63;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_BADNUM   = 3'd1;
    localparam logic [2:0] E_UNTERM   = 3'd2;
    localparam logic [2:0] E_UNKNOWN  = 3'd3;
    localparam logic [2:0] E_OVERFLOW = 3'd4;

    localparam logic [1:0] REG_EAT_COMMENTS = 2'd0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [5:0]            tok_kind;
        logic [OffsetBits-1:0] tok_start;
        logic [OffsetBits:0]   tok_end;
        logic [ValueBits-1:0]  tok_value;
        logic [2:0]            tok_error;
        logic                  tok_last;
    } t_out_item;

    // One scanned byte's worth of results: up to three tokens.
    typedef struct packed {
        logic [2:0]      valid;
        t_out_item [2:0] tok;
    } t_tok_group;

    function automatic logic [5:0] kw_kind(input logic [39:0] pfx, input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (len == 3'd3 && pfx == {16'h0, "tni"}) k = K_KW_BASE;
        if (len == 3'd2 && pfx == {24'h0, "fi"}) k = K_KW_BASE + 6'd1;
        if (len == 3'd4 && pfx == {8'h0, "esle"}) k = K_KW_BASE + 6'd2;
        if (len == 3'd2 && pfx == {24'h0, "od"}) k = K_KW_BASE + 6'd3;
        if (len == 3'd5 && pfx == "elihw") k = K_KW_BASE + 6'd4;
        if (len == 3'd4 && pfx == {8'h0, "daer"}) k = K_KW_BASE + 6'd5;
        if (len == 3'd5 && pfx == "etirw") k = K_KW_BASE + 6'd6;
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

endpackage

// File: hw/rtl/sts_front.sv
module sts_front import sts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_eat,
    input  logic       i_fire,
    input  t_in_item   i_item,
    output t_tok_group o_group
);

    t_mode                 r_mode, n_mode;
    logic [OffsetBits:0]   r_off, n_off;
    logic [OffsetBits-1:0] r_begin, n_begin;
    logic [ValueBits-1:0]  r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic [39:0]           r_pfx, n_pfx;
    logic [2:0]            r_len, n_len;
    logic                  r_star, n_star;

    t_tok_group g;
    logic [1:0] cnt;
    logic [7:0] c;
    logic       consumed;
    logic [OffsetBits:0] p, nx;
    logic [ValueBits+3:0] mul;
    logic [ValueBits+3:0] sum;
    logic [3:0] d;

    function automatic logic [OffsetBits-1:0] sat_start(input logic [OffsetBits:0] v);
        return v[OffsetBits] ? {OffsetBits{1'b1}} : v[OffsetBits-1:0];
    endfunction

    // Token held in mode m, ending at e; K_NONE marks no token. Reads the
    // next-state start, value and identifier fields as they stand at the call.
    function automatic void flush_tok(input t_mode m, input logic [OffsetBits:0] e,
                                      output t_out_item t);
        t = '0; t.tok_start = n_begin; t.tok_end = e; t.tok_kind = K_NONE;
        case (m)
            M_SLASH:  t.tok_kind = K_DIV;
            M_LINE:   if (!i_eat) t.tok_kind = K_LINECOM;
            M_BLOCK:  begin t.tok_kind = K_ERROR; t.tok_error = E_UNTERM; end
            M_ZERO:   t.tok_kind = K_NUMBER;
            M_BADNUM: begin t.tok_kind = K_ERROR; t.tok_error = E_BADNUM; end
            M_NUM: begin
                if (n_ovf) begin
                    t.tok_kind = K_ERROR; t.tok_value = ValueMax; t.tok_error = E_OVERFLOW;
                end else begin
                    t.tok_kind = K_NUMBER; t.tok_value = n_acc;
                end
            end
            M_IDENT:  t.tok_kind = kw_kind(n_pfx, n_len);
            M_LT:     t.tok_kind = K_LT;
            M_GT:     t.tok_kind = K_GT;
            M_EQ:     t.tok_kind = K_ASSIGN;
            M_BANG:   t.tok_kind = K_NOT;
            M_AMP:    t.tok_kind = K_AMP;
            M_BAR:    t.tok_kind = K_BAR;
            default: ;
        endcase
    endfunction

    always_comb begin
        t_out_item t;
        logic [5:0] pk;
        logic       pk_ok;
        g = '0;
        cnt = 2'd0;
        c = i_item.in_byte;
        p = r_off;
        nx = (p < OffLimit) ? p + 1'b1 : OffLimit;
        n_mode = r_mode; n_begin = r_begin; n_acc = r_acc; n_ovf = r_ovf;
        n_pfx = r_pfx; n_len = r_len; n_star = r_star;
        consumed = 1'b0;
        d = c[3:0] - 4'd0;
        mul = {4'd0, r_acc} * (ValueBits+4)'(10);
        sum = mul + (ValueBits+4)'(c - "0");
        pk = K_NONE; pk_ok = 1'b0;
        t = '0;

        unique case (r_mode)
            M_SLASH: begin
                if (c == "/") begin
                    n_mode = M_LINE; consumed = 1'b1;
                end else if (c == "*") begin
                    n_mode = M_BLOCK; n_star = 1'b0; consumed = 1'b1;
                end
            end
            M_LINE: begin
                consumed = 1'b1;
                if (c == 8'h0a) begin
                    if (!i_eat) begin
                        t = '0; t.tok_kind = K_LINECOM; t.tok_start = r_begin; t.tok_end = nx;
                        g.tok[cnt] = t; g.valid[cnt] = 1'b1; cnt = cnt + 2'd1;
                    end
                    n_mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                consumed = 1'b1;
                if (r_star && c == "/") begin
                    if (!i_eat) begin
                        t = '0; t.tok_kind = K_BLOCKCOM; t.tok_start = r_begin; t.tok_end = nx;
                        g.tok[cnt] = t; g.valid[cnt] = 1'b1; cnt = cnt + 2'd1;
                    end
                    n_mode = M_IDLE; n_star = 1'b0;
                end else begin
                    n_star = (c == "*");
                end
            end
            M_ZERO: if (is_digit(c)) begin
                n_mode = M_BADNUM; consumed = 1'b1;
            end
            M_BADNUM: if (is_digit(c)) consumed = 1'b1;
            M_NUM: if (is_digit(c)) begin
                consumed = 1'b1;
                if (!r_ovf) begin
                    if (sum > (ValueBits+4)'(ValueMax)) begin
                        n_ovf = 1'b1; n_acc = ValueMax;
                    end else begin
                        n_acc = sum[ValueBits-1:0];
                    end
                end
            end
            M_IDENT: if (is_letter(c) || is_digit(c) || c == "_") begin
                if (r_len < 3'd5) n_pfx = r_pfx | ({32'd0, c} << {r_len, 3'b000});
                if (r_len < 3'd6) n_len = r_len + 3'd1;
                consumed = 1'b1;
            end
            M_LT: begin
                pk_ok = (c == "=") || (c == "<"); pk = (c == "=") ? K_LE : K_SHL;
            end
            M_GT: begin
                pk_ok = (c == "=") || (c == ">"); pk = (c == "=") ? K_GE : K_SHR;
            end
            M_EQ:   begin pk_ok = (c == "="); pk = K_EQ; end
            M_BANG: begin pk_ok = (c == "="); pk = K_NE; end
            M_AMP:  begin pk_ok = (c == "&"); pk = K_ANDAND; end
            M_BAR:  begin pk_ok = (c == "|"); pk = K_OROR; end
            default: ;
        endcase
        if (pk_ok) begin
            t = '0; t.tok_kind = pk; t.tok_start = r_begin; t.tok_end = nx;
            g.tok[cnt] = t; g.valid[cnt] = 1'b1; cnt = cnt + 2'd1;
            n_mode = M_IDLE; consumed = 1'b1;
        end

        if (!consumed) begin
            flush_tok(r_mode, p, t);
            if (t.tok_kind != K_NONE) begin
                g.tok[cnt] = t; g.valid[cnt] = 1'b1; cnt = cnt + 2'd1;
            end
            n_mode = M_IDLE;
            n_begin = sat_start(p);
            t = '0; t.tok_start = sat_start(p); t.tok_end = nx; t.tok_kind = K_NONE;
            case (c)
                "{": t.tok_kind = K_LBRACE;
                "}": t.tok_kind = K_RBRACE;
                "[": t.tok_kind = K_LBRACK;
                "]": t.tok_kind = K_RBRACK;
                "(": t.tok_kind = K_LPAREN;
                ")": t.tok_kind = K_RPAREN;
                ";": t.tok_kind = K_SEMI;
                ":": t.tok_kind = K_COLON;
                ",": t.tok_kind = K_COMMA;
                "+": t.tok_kind = K_PLUS;
                "-": t.tok_kind = K_MINUS;
                "*": t.tok_kind = K_STAR;
                "%": t.tok_kind = K_MOD;
                "/": n_mode = M_SLASH;
                "<": n_mode = M_LT;
                ">": n_mode = M_GT;
                "=": n_mode = M_EQ;
                "!": n_mode = M_BANG;
                "&": n_mode = M_AMP;
                "|": n_mode = M_BAR;
                "0": n_mode = M_ZERO;
                default: begin
                    if (is_digit(c)) begin
                        n_mode = M_NUM; n_acc = ValueBits'(d); n_ovf = 1'b0;
                    end else if (is_letter(c) || c == "_") begin
                        n_mode = M_IDENT; n_pfx = {32'd0, c}; n_len = 3'd1;
                    end else if (!(c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)) begin
                        t.tok_kind = K_ERROR; t.tok_error = E_UNKNOWN;
                    end
                end
            endcase
            if (t.tok_kind != K_NONE) begin
                g.tok[cnt] = t; g.valid[cnt] = 1'b1; cnt = cnt + 2'd1;
            end
        end

        n_off = nx;

        if (i_item.in_last) begin
            flush_tok(n_mode, nx, t);
            if (t.tok_kind != K_NONE) begin
                g.tok[cnt] = t; g.valid[cnt] = 1'b1; cnt = cnt + 2'd1;
            end
            t = '0; t.tok_kind = K_END; t.tok_start = sat_start(nx);
            t.tok_end = nx; t.tok_last = 1'b1;
            g.tok[cnt] = t; g.valid[cnt] = 1'b1;
            n_mode = M_IDLE; n_off = '0; n_begin = '0; n_acc = '0; n_ovf = 1'b0;
            n_pfx = '0; n_len = 3'd0; n_star = 1'b0;
        end
        if (!i_fire) g.valid = 3'b000;
        o_group = g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_off <= '0; r_begin <= '0; r_acc <= '0; r_ovf <= 1'b0;
            r_pfx <= '0; r_len <= 3'd0; r_star <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode; r_off <= n_off; r_begin <= n_begin; r_acc <= n_acc;
            r_ovf <= n_ovf; r_pfx <= n_pfx; r_len <= n_len; r_star <= n_star;
        end
    end

endmodule

// File: hw/rtl/sts_queue.sv
module sts_queue import sts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tok_group i_group,
    output logic       o_room,
    output logic       o_valid,
    output t_out_item  o_item,
    input  logic       i_stall
);

    t_out_item            r_mem [QueueDepth];
    logic [QueueAw-1:0]   r_wp, r_rp;
    logic [QueueAw:0]     r_cnt;
    logic [1:0]           wn;
    logic                 pop;
    logic [QueueAw-1:0]   a1, a2;

    assign wn = {1'b0, i_group.valid[0]} + {1'b0, i_group.valid[1]}
              + {1'b0, i_group.valid[2]};
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    // Room for a full group of three regardless of the output side.
    assign o_room  = r_cnt <= (QueueAw+1)'(QueueDepth - 3);
    assign a1 = r_wp + QueueAw'(1);
    assign a2 = r_wp + QueueAw'(2);

    always_ff @(posedge i_clk) begin
        // Groups are compacted: valid bits fill from index zero.
        if (i_group.valid[0]) r_mem[r_wp] <= i_group.tok[0];
        if (i_group.valid[1]) r_mem[a1] <= i_group.tok[1];
        if (i_group.valid[2]) r_mem[a2] <= i_group.tok[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QueueAw'(wn);
            if (pop) r_rp <= r_rp + QueueAw'(1);
            r_cnt <= r_cnt + (QueueAw+1)'(wn) - (QueueAw+1)'(pop);
        end
    end

endmodule

// File: hw/rtl/source_token_scanner_top.sv
// Source token scanner.
// Input channel: one source byte per item with a last-byte mark; an item is
// taken when i_in_valid is high and o_in_stall is low. Output channel: one
// token per item (kind, start, end, value, error code, last mark), taken when
// o_out_valid is high and i_out_stall is low.
// Each byte is classified combinationally by the front end, which writes
// the zero to three tokens it produces into a four-entry queue in that same
// cycle; the queue head drives the output, so a token passes through a queue
// register before it appears. The front end takes one byte per cycle
// while the queue has room for three tokens, i.e. holds at most one; a
// receiver that takes every cycle therefore sustains one byte per cycle
// except where a byte produces two or more tokens.
// When the receiver stalls, the queue fills and o_in_stall rises; nothing is
// lost. Reset clears the scan state, the queue and eat_comments (register 0
// at APB address 0, read back on prdata).
module source_token_scanner_top import sts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_eat;
    logic       room;
    logic       fire;
    t_tok_group grp;

    assign pready = 1'b1;
    // Only register 0 exists; any other address reads as zero.
    assign prdata = (paddr[1:0] == REG_EAT_COMMENTS) ? {31'd0, r_eat} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eat <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_EAT_COMMENTS) begin
            r_eat <= pwdata[0];
        end
    end

    assign o_in_stall = !room;
    assign fire = i_in_valid && room;

    sts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_eat(r_eat), .i_fire(fire),
        .i_item(i_in_item), .o_group(grp)
    );

    sts_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_group(grp), .o_room(room),
        .o_valid(o_out_valid), .o_item(o_out_item), .i_stall(i_out_stall)
    );

endmodule

// File: hw/rtl/sts_checker.sv
`include "assert_macros.svh"
module sts_checker import sts_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled token changed")
    `CHK_IMPLY(a_last_end, i_clk, i_rst_n, o_out_valid && o_out_item.tok_last, o_out_item.tok_kind == K_END, "last mark on non-end token")
    `CHK_IMPLY(a_err_kind, i_clk, i_rst_n, o_out_valid && o_out_item.tok_error != E_NONE, o_out_item.tok_kind == K_ERROR, "error code on non-error token")
    `CHK_IMPLY(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid, "input stalled while no token waits")
endmodule

bind source_token_scanner_top sts_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
);
